// ===== sv/smq_pkg.sv =====
// Shared types, codes and the glyph font for the scrolling marquee.
`default_nettype none
package smq_pkg;

  localparam int unsigned ROWS     = 5;
  localparam int unsigned MAX_COLS = 6;  // five glyph columns plus the trailing blank

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_SCAN = 1'b1
  } op_e;

  typedef enum logic {
    KIND_COLUMN = 1'b0,
    KIND_SCAN   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [2:0]      count;
    logic [4:0][4:0] cols;   // cols[0] enters the frame first; unused columns are zero
  } glyph_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    op_e                      op;
    logic [2:0]               count;  // columns to shift in (1..6), push only
    logic [MAX_COLS-1:0][4:0] cols;
  } cmd_t;

  function automatic glyph_t mk_glyph(input logic [2:0] n, input logic [4:0] c0,
                                      input logic [4:0] c1, input logic [4:0] c2,
                                      input logic [4:0] c3, input logic [4:0] c4);
    glyph_t g;
    g.count = n;
    g.cols  = {c4, c3, c2, c1, c0};
    return g;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] ch);
    glyph_t g;
    unique case (ch) inside
      "A":      g = mk_glyph(3'd3, 5'h0F, 5'h14, 5'h0F, 5'h00, 5'h00);
      "B":      g = mk_glyph(3'd3, 5'h1F, 5'h15, 5'h0A, 5'h00, 5'h00);
      "C":      g = mk_glyph(3'd3, 5'h1F, 5'h11, 5'h11, 5'h00, 5'h00);
      "D":      g = mk_glyph(3'd3, 5'h1F, 5'h11, 5'h0E, 5'h00, 5'h00);
      "E":      g = mk_glyph(3'd3, 5'h1F, 5'h15, 5'h11, 5'h00, 5'h00);
      "F":      g = mk_glyph(3'd3, 5'h1F, 5'h14, 5'h14, 5'h00, 5'h00);
      "G", "6": g = mk_glyph(3'd3, 5'h1F, 5'h15, 5'h17, 5'h00, 5'h00);
      "H":      g = mk_glyph(3'd3, 5'h1F, 5'h04, 5'h1F, 5'h00, 5'h00);
      "I":      g = mk_glyph(3'd3, 5'h11, 5'h1F, 5'h11, 5'h00, 5'h00);
      "J":      g = mk_glyph(3'd3, 5'h03, 5'h01, 5'h1F, 5'h00, 5'h00);
      "K":      g = mk_glyph(3'd3, 5'h1F, 5'h04, 5'h1B, 5'h00, 5'h00);
      "L":      g = mk_glyph(3'd3, 5'h1F, 5'h01, 5'h01, 5'h00, 5'h00);
      "M":      g = mk_glyph(3'd5, 5'h1F, 5'h08, 5'h04, 5'h08, 5'h1F);
      "N":      g = mk_glyph(3'd4, 5'h1F, 5'h08, 5'h04, 5'h1F, 5'h00);
      "O", "0": g = mk_glyph(3'd3, 5'h1F, 5'h11, 5'h1F, 5'h00, 5'h00);
      "P":      g = mk_glyph(3'd3, 5'h1F, 5'h14, 5'h1C, 5'h00, 5'h00);
      "Q":      g = mk_glyph(3'd4, 5'h1F, 5'h11, 5'h1F, 5'h01, 5'h00);
      "R":      g = mk_glyph(3'd3, 5'h1F, 5'h14, 5'h1B, 5'h00, 5'h00);
      "S", "5": g = mk_glyph(3'd3, 5'h1D, 5'h15, 5'h17, 5'h00, 5'h00);
      "T":      g = mk_glyph(3'd3, 5'h10, 5'h1F, 5'h10, 5'h00, 5'h00);
      "U":      g = mk_glyph(3'd3, 5'h1F, 5'h01, 5'h1F, 5'h00, 5'h00);
      "V":      g = mk_glyph(3'd3, 5'h1E, 5'h01, 5'h1E, 5'h00, 5'h00);
      "W":      g = mk_glyph(3'd5, 5'h1E, 5'h01, 5'h1E, 5'h01, 5'h1E);
      "X":      g = mk_glyph(3'd3, 5'h1B, 5'h04, 5'h1B, 5'h00, 5'h00);
      "Y":      g = mk_glyph(3'd3, 5'h18, 5'h07, 5'h18, 5'h00, 5'h00);
      "Z":      g = mk_glyph(3'd3, 5'h13, 5'h15, 5'h19, 5'h00, 5'h00);
      " ":      g = mk_glyph(3'd1, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00);
      "&":      g = mk_glyph(3'd5, 5'h0C, 5'h12, 5'h09, 5'h12, 5'h0C);
      "1":      g = mk_glyph(3'd2, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00);
      "2":      g = mk_glyph(3'd3, 5'h17, 5'h15, 5'h1D, 5'h00, 5'h00);
      "3":      g = mk_glyph(3'd3, 5'h11, 5'h15, 5'h1F, 5'h00, 5'h00);
      "4":      g = mk_glyph(3'd3, 5'h1C, 5'h04, 5'h1F, 5'h00, 5'h00);
      "7":      g = mk_glyph(3'd3, 5'h10, 5'h10, 5'h1F, 5'h00, 5'h00);
      "8":      g = mk_glyph(3'd3, 5'h1F, 5'h15, 5'h1F, 5'h00, 5'h00);
      "9":      g = mk_glyph(3'd3, 5'h1C, 5'h14, 5'h1F, 5'h00, 5'h00);
      ".":      g = mk_glyph(3'd1, 5'h01, 5'h00, 5'h00, 5'h00, 5'h00);
      "u":      g = mk_glyph(3'd3, 5'h0E, 5'h1C, 5'h0E, 5'h00, 5'h00);
      "d":      g = mk_glyph(3'd3, 5'h1C, 5'h0E, 5'h1C, 5'h00, 5'h00);
      default:  g = mk_glyph(3'd0, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== sv/smq_front.sv =====
// Front end: accepts items, looks up glyphs and builds commands for the queue.
`default_nettype none
module smq_front (
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         op_i,
  input  logic [7:0]   char_code_i,
  input  logic         end_space_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output smq_pkg::cmd_t q_cmd_o
);
  import smq_pkg::*;

  glyph_t     glyph;
  logic [2:0] count;
  op_e        op;

  always_comb begin
    op    = op_e'(op_i);
    glyph = glyph_lookup(char_code_i);
    // columns past the glyph are zero, so the blank column is already in place
    count = glyph.count + {2'b00, end_space_i};

    q_cmd_o.op    = op;
    q_cmd_o.count = count;
    q_cmd_o.cols  = {5'h00, glyph.cols};
  end

  assign in_ready_o = !q_full_i;
  // an unknown character without a trailing blank produces nothing: drop it
  assign q_push_o   = in_valid_i && in_ready_o && (op == OP_SCAN || count != 3'd0);

endmodule
`default_nettype wire

// ===== sv/smq_fifo.sv =====
// Two-entry command queue between front and back.
`default_nettype none
module smq_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  smq_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output smq_pkg::cmd_t head_cmd_o
);
  import smq_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/smq_back.sv =====
// Back end: shifts glyph columns into the frame, runs the scan and registers results.
`default_nettype none
module smq_back #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  smq_pkg::cmd_t head_cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          result_kind_o,
  output logic [4:0]    column_bits_o,
  output logic [3:0]    scan_column_o,
  output logic [2:0]    scan_row_o,
  output logic          led_on_o,
  output logic          last_o
);
  import smq_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS);

  logic [COLUMNS-1:0][4:0] frame_q, frame_d;
  logic [CW-1:0]           scan_col_q, scan_col_d;
  logic [2:0]              scan_row_q, scan_row_d;
  logic [2:0]              idx_q, idx_d;
  logic                    out_valid_q, out_valid_d;

  kind_e      kind_q, kind_d;
  logic [4:0] col_bits_q, col_bits_d;
  logic [3:0] scol_q, scol_d;
  logic [2:0] srow_q, srow_d;
  logic       led_q, led_d;
  logic       last_q, last_d;

  logic        emit;
  logic        is_last;
  logic [4:0]  cur_col;
  logic [31:0] col_ext;

  always_comb begin
    emit    = head_valid_i && (!out_valid_q || out_ready_i);
    is_last = (idx_q == head_cmd_i.count - 3'd1);
    cur_col = head_cmd_i.cols[idx_q];
    col_ext = 32'(scan_col_q);

    frame_d     = frame_q;
    scan_col_d  = scan_col_q;
    scan_row_d  = scan_row_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    col_bits_d  = col_bits_q;
    scol_d      = scol_q;
    srow_d      = srow_q;
    led_d       = led_q;
    last_d      = last_q;
    pop_o       = 1'b0;

    if (emit) begin
      out_valid_d = 1'b1;
      if (head_cmd_i.op == OP_SCAN) begin
        kind_d     = KIND_SCAN;
        col_bits_d = 5'h00;
        scol_d     = col_ext[3:0];
        srow_d     = scan_row_q;
        led_d      = frame_q[scan_col_q][scan_row_q];
        last_d     = 1'b1;
        pop_o      = 1'b1;
        // row first; column advances when the row wraps
        if (scan_row_q == 3'(ROWS - 1)) begin
          scan_row_d = 3'd0;
          scan_col_d = (scan_col_q == CW'(COLUMNS - 1)) ? '0 : scan_col_q + CW'(1);
        end else begin
          scan_row_d = scan_row_q + 3'd1;
        end
      end else begin
        kind_d     = KIND_COLUMN;
        col_bits_d = cur_col;
        scol_d     = 4'd0;
        srow_d     = 3'd0;
        led_d      = 1'b0;
        last_d     = is_last;
        frame_d    = {frame_q[COLUMNS-2:0], cur_col};
        if (is_last) begin
          idx_d = 3'd0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      scan_col_q  <= '0;
      scan_row_q  <= 3'd0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      frame_q     <= frame_d;
      scan_col_q  <= scan_col_d;
      scan_row_q  <= scan_row_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    col_bits_q <= col_bits_d;
    scol_q     <= scol_d;
    srow_q     <= srow_d;
    led_q      <= led_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign column_bits_o = col_bits_q;
  assign scan_column_o = scol_q;
  assign scan_row_o    = srow_q;
  assign led_on_o      = led_q;
  assign last_o        = last_q;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_row_q < 3'(ROWS)) else $error("scan row out of range");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && head_cmd_i.op == OP_PUSH) |-> idx_q < head_cmd_i.count)
    else $error("column index past glyph");
  a_scan_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_SCAN) |-> last_q)
    else $error("scan report not marked last");

endmodule
`default_nettype wire

// ===== sv/scrolling_glyph_marquee.sv =====
// Scrolling marquee top level: classifying front end, command queue, frame back end.
// An item is written into the queue, then the back end registers its first result.
// Throughput: a push shifts in one column per cycle (1 to 6, glyph plus blank) and a scan
// tick gives one result, unless the output stalls; the back end's single shifter sets this.
// The two-entry queue lets the front accept items while the back end or the output stalls.
// Reset clears the frame (all LEDs off), the scan position, the queue and the output.
`default_nettype none
module scrolling_glyph_marquee #(
  parameter int unsigned COLUMNS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] char_code_i,
  input  logic       end_space_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [4:0] column_bits_o,
  output logic [3:0] scan_column_o,
  output logic [2:0] scan_row_o,
  output logic       led_on_o,
  output logic       last_o
);
  import smq_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  smq_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .end_space_i (end_space_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  smq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  smq_back #(
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_cmd_i    (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .column_bits_o (column_bits_o),
    .scan_column_o (scan_column_o),
    .scan_row_o    (scan_row_o),
    .led_on_o      (led_on_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ===== test/scrolling_glyph_marquee_tb.sv =====
// Self-checking testbench for the scrolling glyph marquee: font pushes and scan ticks.
module scrolling_glyph_marquee_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smq_pkg::*;

  localparam int COLS       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 132;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] cols;
    logic [3:0] scan_col;
    logic [2:0] scan_row;
    logic       led;
    logic       is_last;
  } marquee_res_t;

  // n columns, first column in the top five bits
  typedef struct packed {
    logic [2:0]  n;
    logic [24:0] bits;
  } glyph_cols_t;

  typedef enum {CHK_PREDICT, CHK_NONE, CHK_TYPED} row_check_e;

  typedef struct {
    op_e          op;
    logic [7:0]   ch;
    logic         es;
    row_check_e   chk;
    marquee_res_t res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       op = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic       end_space = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       result_kind_o;
  logic [4:0] column_bits_o;
  logic [3:0] scan_column_o;
  logic [2:0] scan_row_o;
  logic       led_on_o;
  logic       last_o;

  int send_idle = 33;
  int recv_idle = 81;
  int errors = 0;
  int stall_cycles = 0;

  logic [4:0]   frame_mem [COLS];
  int           scan_col_at;
  int           scan_row_at;
  marquee_res_t frame_out_q [$];
  stim_row_t    stim_tab [$];

  scrolling_glyph_marquee #(.COLUMNS(COLS)) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .op_i          (op),
    .char_code_i   (char_code),
    .end_space_i   (end_space),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind_o),
    .column_bits_o (column_bits_o),
    .scan_column_o (scan_column_o),
    .scan_row_o    (scan_row_o),
    .led_on_o      (led_on_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic glyph_cols_t font_columns(input logic [7:0] ch);
    glyph_cols_t f;
    case (ch)
      "A":      f = {3'd3, 5'h0F, 5'h14, 5'h0F, 10'h0};
      "B":      f = {3'd3, 5'h1F, 5'h15, 5'h0A, 10'h0};
      "C":      f = {3'd3, 5'h1F, 5'h11, 5'h11, 10'h0};
      "D":      f = {3'd3, 5'h1F, 5'h11, 5'h0E, 10'h0};
      "E":      f = {3'd3, 5'h1F, 5'h15, 5'h11, 10'h0};
      "F":      f = {3'd3, 5'h1F, 5'h14, 5'h14, 10'h0};
      "G", "6": f = {3'd3, 5'h1F, 5'h15, 5'h17, 10'h0};
      "H":      f = {3'd3, 5'h1F, 5'h04, 5'h1F, 10'h0};
      "I":      f = {3'd3, 5'h11, 5'h1F, 5'h11, 10'h0};
      "J":      f = {3'd3, 5'h03, 5'h01, 5'h1F, 10'h0};
      "K":      f = {3'd3, 5'h1F, 5'h04, 5'h1B, 10'h0};
      "L":      f = {3'd3, 5'h1F, 5'h01, 5'h01, 10'h0};
      "M":      f = {3'd5, 5'h1F, 5'h08, 5'h04, 5'h08, 5'h1F};
      "N":      f = {3'd4, 5'h1F, 5'h08, 5'h04, 5'h1F, 5'h00};
      "O", "0": f = {3'd3, 5'h1F, 5'h11, 5'h1F, 10'h0};
      "P":      f = {3'd3, 5'h1F, 5'h14, 5'h1C, 10'h0};
      "Q":      f = {3'd4, 5'h1F, 5'h11, 5'h1F, 5'h01, 5'h00};
      "R":      f = {3'd3, 5'h1F, 5'h14, 5'h1B, 10'h0};
      "S", "5": f = {3'd3, 5'h1D, 5'h15, 5'h17, 10'h0};
      "T":      f = {3'd3, 5'h10, 5'h1F, 5'h10, 10'h0};
      "U":      f = {3'd3, 5'h1F, 5'h01, 5'h1F, 10'h0};
      "V":      f = {3'd3, 5'h1E, 5'h01, 5'h1E, 10'h0};
      "W":      f = {3'd5, 5'h1E, 5'h01, 5'h1E, 5'h01, 5'h1E};
      "X":      f = {3'd3, 5'h1B, 5'h04, 5'h1B, 10'h0};
      "Y":      f = {3'd3, 5'h18, 5'h07, 5'h18, 10'h0};
      "Z":      f = {3'd3, 5'h13, 5'h15, 5'h19, 10'h0};
      " ":      f = {3'd1, 25'h0};
      "&":      f = {3'd5, 5'h0C, 5'h12, 5'h09, 5'h12, 5'h0C};
      "1":      f = {3'd2, 5'h00, 5'h1F, 15'h0};
      "2":      f = {3'd3, 5'h17, 5'h15, 5'h1D, 10'h0};
      "3":      f = {3'd3, 5'h11, 5'h15, 5'h1F, 10'h0};
      "4":      f = {3'd3, 5'h1C, 5'h04, 5'h1F, 10'h0};
      "7":      f = {3'd3, 5'h10, 5'h10, 5'h1F, 10'h0};
      "8":      f = {3'd3, 5'h1F, 5'h15, 5'h1F, 10'h0};
      "9":      f = {3'd3, 5'h1C, 5'h14, 5'h1F, 10'h0};
      ".":      f = {3'd1, 5'h01, 20'h0};
      "u":      f = {3'd3, 5'h0E, 5'h1C, 5'h0E, 10'h0};
      "d":      f = {3'd3, 5'h1C, 5'h0E, 5'h1C, 10'h0};
      default:  f = '0;
    endcase
    return f;
  endfunction

  function automatic marquee_res_t make_res(input kind_e k, input logic [4:0] cols,
                                            input logic [3:0] sc, input logic [2:0] sr,
                                            input logic led, input logic is_last);
    marquee_res_t r;
    r.kind     = k;
    r.cols     = cols;
    r.scan_col = sc;
    r.scan_row = sr;
    r.led      = led;
    r.is_last  = is_last;
    return r;
  endfunction

  // Advance the frame and scan position for one item; queue the results if asked.
  task automatic scroll_and_scan(input op_e op_in, input logic [7:0] ch, input logic es,
                                 input bit enqueue);
    glyph_cols_t  g;
    int           total;
    logic [4:0]   col;
    marquee_res_t r;
    if (op_in == OP_SCAN) begin
      r = make_res(KIND_SCAN, 5'h00, scan_col_at[3:0], scan_row_at[2:0],
                   frame_mem[scan_col_at][scan_row_at], 1'b1);
      if (enqueue) frame_out_q.push_back(r);
      scan_row_at++;
      if (scan_row_at >= ROWS) begin
        scan_row_at = 0;
        scan_col_at = (scan_col_at + 1) % COLS;
      end
    end else begin
      g = font_columns(ch);
      total = int'(g.n) + int'(es);
      for (int k = 0; k < total; k++) begin
        col = (k < int'(g.n)) ? g.bits[24 - 5*k -: 5] : 5'h00;
        for (int i = COLS - 1; i > 0; i--) frame_mem[i] = frame_mem[i-1];
        frame_mem[0] = col;
        r = make_res(KIND_COLUMN, col, 4'd0, 3'd0, 1'b0, k == total - 1);
        if (enqueue) frame_out_q.push_back(r);
      end
    end
  endtask

  task automatic add_row(input op_e op_in, input logic [7:0] ch, input logic es,
                         input row_check_e chk, input marquee_res_t res);
    stim_row_t row;
    row.op  = op_in;
    row.ch  = ch;
    row.es  = es;
    row.chk = chk;
    row.res = res;
    stim_tab.push_back(row);
  endtask

  // Entered and left at a falling edge with no drive made in that step yet.
  task automatic send_item(input op_e op_in, input logic [7:0] ch, input logic es,
                           input row_check_e chk, input marquee_res_t res);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_in;
    char_code <= ch;
    end_space <= es;
    do @(posedge clk); while (!in_ready_o);
    scroll_and_scan(op_in, ch, es, chk == CHK_PREDICT);
    if (chk == CHK_TYPED) frame_out_q.push_back(res);
    @(negedge clk);
  endtask

  // Hold the sender off until every pending result has come out.
  task automatic drain_display();
    in_valid <= 1'b0;
    do @(negedge clk); while (frame_out_q.size() != 0);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    marquee_res_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (frame_out_q.size() == 0) begin
        $error("result item with nothing pending: kind %0h bits %0h", result_kind_o,
               column_bits_o);
        errors++;
      end else begin
        want = frame_out_q.pop_front();
        check_field("result_kind", want.kind, result_kind_o);
        check_field("column_bits", want.cols, column_bits_o);
        check_field("scan_column", want.scan_col, scan_column_o);
        check_field("scan_row", want.scan_row, scan_row_o);
        check_field("led_on", want.led, led_on_o);
        check_field("last", want.is_last, last_o);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    op_e        op_r;
    logic [7:0] ch_r;
    logic       es_r;
    int         pick;

    for (int i = 0; i < COLS; i++) frame_mem[i] = 5'h00;
    scan_col_at = 0;
    scan_row_at = 0;

    // blank frame after reset: first scan reads column 0 row 0 dark
    add_row(OP_SCAN, 8'h00, 1'b0, CHK_TYPED,
            make_res(KIND_SCAN, 5'h00, 4'd0, 3'd0, 1'b0, 1'b1));
    // unknown character without blank: nothing comes out
    add_row(OP_PUSH, 8'h00, 1'b0, CHK_NONE, '0);
    // unknown character with blank: only the blank column
    add_row(OP_PUSH, 8'hFF, 1'b1, CHK_TYPED,
            make_res(KIND_COLUMN, 5'h00, 4'd0, 3'd0, 1'b0, 1'b1));
    add_row(OP_PUSH, " ", 1'b0, CHK_TYPED,
            make_res(KIND_COLUMN, 5'h00, 4'd0, 3'd0, 1'b0, 1'b1));
    add_row(OP_PUSH, ".", 1'b0, CHK_TYPED,
            make_res(KIND_COLUMN, 5'h01, 4'd0, 3'd0, 1'b0, 1'b1));
    add_row(OP_PUSH, "M", 1'b1, CHK_PREDICT, '0);
    add_row(OP_PUSH, "W", 1'b0, CHK_PREDICT, '0);
    add_row(OP_PUSH, "&", 1'b1, CHK_PREDICT, '0);
    // shared glyphs (G/6, O/0, S/5), then more glyphs and an unknown character
    add_row(OP_PUSH, "G", 1'b0, CHK_PREDICT, '0);
    add_row(OP_PUSH, "6", 1'b1, CHK_PREDICT, '0);
    add_row(OP_PUSH, "O", 1'b1, CHK_PREDICT, '0);
    add_row(OP_PUSH, "0", 1'b0, CHK_PREDICT, '0);
    add_row(OP_PUSH, "S", 1'b0, CHK_PREDICT, '0);
    add_row(OP_PUSH, "5", 1'b1, CHK_PREDICT, '0);
    add_row(OP_PUSH, "u", 1'b0, CHK_PREDICT, '0);
    add_row(OP_PUSH, "d", 1'b1, CHK_PREDICT, '0);
    add_row(OP_PUSH, "Q", 1'b0, CHK_PREDICT, '0);
    add_row(OP_PUSH, "N", 1'b1, CHK_PREDICT, '0);
    add_row(OP_PUSH, "1", 1'b0, CHK_PREDICT, '0);
    add_row(OP_PUSH, "Z", 1'b1, CHK_PREDICT, '0);
    add_row(OP_PUSH, 8'h80, 1'b0, CHK_NONE, '0);
    // scan fields other than op are ignored
    add_row(OP_SCAN, 8'hFF, 1'b1, CHK_PREDICT, '0);
    add_row(OP_SCAN, 8'h55, 1'b0, CHK_PREDICT, '0);
    add_row(OP_SCAN, 8'hAA, 1'b1, CHK_PREDICT, '0);
    add_row(OP_SCAN, 8'h00, 1'b0, CHK_PREDICT, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_tab[i])
      send_item(stim_tab[i].op, stim_tab[i].ch, stim_tab[i].es, stim_tab[i].chk,
                stim_tab[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 33; recv_idle = 81; end
        1: begin send_idle = 81; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        es_r = $urandom_range(0, 1);
        if (pick < 40) begin
          op_r = OP_SCAN;
          ch_r = $urandom_range(0, 255);
        end else if (pick < 85) begin
          op_r = OP_PUSH;
          do ch_r = $urandom_range(32, 122); while (font_columns(ch_r) == '0);
        end else begin
          op_r = OP_PUSH;
          ch_r = $urandom_range(0, 255);
        end
        send_item(op_r, ch_r, es_r, CHK_PREDICT, '0);
        if (phase == 1 && i == RAND_PER_PHASE / 2) drain_display();
      end
      drain_display();
    end

    // catch any stray result items after the last expected one
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
